FILE: sv/json_key_value_extractor_defines.svh
// Assertion macros shared by the json_key_value_extractor RTL.
// No dependencies; the asserting module must provide clk and rst_n.
`ifndef JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH
`define JSON_KEY_VALUE_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define JKV_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define JKV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/jkv_pkg.sv
// Shared types and codes for the JSON key/value extractor.
// No dependencies; used by jkv_out_fifo, jkv_scan_core and the top level.
`default_nettype none

package jkv_pkg;

    typedef struct packed {
        logic [7:0] value_byte;
        logic       value_valid;
        logic [1:0] result_status;
        logic       result_last;
    } result_t;

    localparam logic [1:0] STATUS_FOUND     = 2'd0;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd1;
    localparam logic [1:0] STATUS_MALFORMED = 2'd2;

    localparam logic [1:0] CFG_KEY_LOW    = 2'd0;
    localparam logic [1:0] CFG_KEY_HIGH   = 2'd1;
    localparam logic [1:0] CFG_KEY_LENGTH = 2'd2;
    localparam logic [1:0] CFG_VALUE_LIM  = 2'd3;

endpackage

`default_nettype wire

FILE: sv/jkv_out_fifo.sv
// Two-entry result skid buffer between the scan core and the output stream.
// Depends on jkv_pkg (result_t).
`default_nettype none

module jkv_out_fifo
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            push,
    input  jkv_pkg::result_t     push_data,
    output logic                 space,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output jkv_pkg::result_t     out_data
);

    logic [1:0]       count_reg;
    jkv_pkg::result_t head_reg;
    jkv_pkg::result_t tail_reg;
    logic             pop;

    assign pop       = out_valid && out_ready;
    assign out_valid = (count_reg != 2'd0);
    assign space     = (count_reg != 2'd2);
    assign out_data  = head_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 2'd0;
        end
        else if (push && !pop)
        begin
            count_reg <= count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_reg <= count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push && !pop)
        begin
            if (count_reg == 2'd0)
            begin
                head_reg <= push_data;
            end
            else
            begin
                tail_reg <= push_data;
            end
        end
        else if (pop && !push)
        begin
            head_reg <= tail_reg;
        end
        else if (pop && push)
        begin
            if (count_reg == 2'd1)
            begin
                head_reg <= push_data;
            end
            else
            begin
                head_reg <= tail_reg;
                tail_reg <= push_data;
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/jkv_scan_core.sv
// Scan core: lookahead window, key compare, phase tracking and value copy.
// Depends on jkv_pkg and json_key_value_extractor_defines.svh.
`default_nettype none
`include "json_key_value_extractor_defines.svh"

module jkv_scan_core
#(
    parameter int KEY_MAX  = 16,
    parameter int NEST_MAX = 255
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic [63:0]  key_low_word,
    input  wire logic [63:0]  key_high_word,
    input  wire logic [4:0]   key_length,
    input  wire logic [12:0]  value_limit,
    input  wire logic         in_valid,
    input  wire logic [7:0]   in_byte,
    input  wire logic         in_last,
    output logic              in_take,
    input  wire logic         space,
    output logic              push,
    output jkv_pkg::result_t  res
);

    localparam int FILL_W  = $clog2(KEY_MAX + 1);
    localparam int DEPTH_W = $clog2(NEST_MAX + 1);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;

    typedef enum logic [2:0] {
        PH_SEARCH,
        PH_SKIPKEY,
        PH_AFTERKEY,
        PH_PRECOLON,
        PH_POSTCOLON,
        PH_VALUE,
        PH_OK,
        PH_BAD
    } phase_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_NEST,
        MODE_QUOTED,
        MODE_BARE
    } mode_t;

    logic [7:0]         win_reg [KEY_MAX];
    logic [7:0]         win_next [KEY_MAX];
    logic [FILL_W-1:0]  fill_reg, fill_next;
    phase_t             phase_reg, phase_next;
    logic [FILL_W-1:0]  skip_reg, skip_next;
    logic               instr_reg, instr_next;
    logic               esc_reg, esc_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    mode_t              mode_reg, mode_next;
    logic [11:0]        emitted_reg, emitted_next;
    logic               last_pend_reg, last_pend_next;

    logic [127:0]       key_vec;
    logic [FILL_W-1:0]  klen;
    logic [11:0]        cap;
    logic               work;
    logic               step;
    logic               lp;
    logic [7:0]         wv [KEY_MAX];
    logic [FILL_W-1:0]  fv;
    logic               handle;
    logic               status_out;
    logic               match;
    logic [7:0]         h;
    logic               is_quote, is_bslash, is_open, is_close, is_blank;
    logic               send_now;
    logic [1:0]         status_code;

    mode_t              start_mode;
    logic [11:0]        v_em;
    logic               v_esc, v_instr;
    logic [DEPTH_W-1:0] v_depth;
    mode_t              v_mode;
    phase_t             vs_phase;
    logic               vs_send, vs_esc, vs_instr;
    logic [DEPTH_W-1:0] vs_depth;

    assign key_vec = {key_high_word, key_low_word};

    always_comb
    begin
        if (key_length == 5'd0)
        begin
            klen = FILL_W'(1);
        end
        else if (int'(key_length) > KEY_MAX)
        begin
            klen = FILL_W'(KEY_MAX);
        end
        else
        begin
            klen = FILL_W'(key_length);
        end
    end

    always_comb
    begin
        if (value_limit == 13'd0)
        begin
            cap = 12'd0;
        end
        else if (value_limit > 13'd4096)
        begin
            cap = 12'd4095;
        end
        else
        begin
            cap = 12'(value_limit - 13'd1);
        end
    end

    assign work       = last_pend_reg || (fill_reg >= klen);
    assign in_take    = in_valid && space && !work;
    assign step       = space && (in_take || work);
    assign lp         = in_take ? in_last : last_pend_reg;
    assign fv         = in_take ? fill_reg + FILL_W'(1) : fill_reg;
    assign handle     = step && (fv != '0) && ((fv >= klen) || lp);
    assign status_out = step && !handle && lp;

    always_comb
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            wv[i] = (in_take && FILL_W'(i) == fill_reg) ? in_byte : win_reg[i];
        end
    end

    always_comb
    begin
        match = (fv >= klen);
        for (int i = 0; i < KEY_MAX; i++)
        begin
            if (FILL_W'(i) < klen && wv[i] != key_vec[8*i +: 8])
            begin
                match = 1'b0;
            end
        end
    end

    assign h         = wv[0];
    assign is_quote  = (h == CH_QUOTE);
    assign is_bslash = (h == CH_BSLASH);
    assign is_open   = h inside {CH_LBRACE, CH_LBRACK};
    assign is_close  = h inside {CH_RBRACE, CH_RBRACK};
    assign is_blank  = h inside {CH_SPACE, CH_TAB};
    assign start_mode = is_open ? MODE_NEST : MODE_BARE;

    // value state seen by the first value byte is a fresh start
    always_comb
    begin
        if (phase_reg == PH_POSTCOLON)
        begin
            v_em    = 12'd0;
            v_esc   = 1'b0;
            v_instr = (start_mode != MODE_NEST);
            v_depth = '0;
            v_mode  = start_mode;
        end
        else
        begin
            v_em    = emitted_reg;
            v_esc   = esc_reg;
            v_instr = instr_reg;
            v_depth = depth_reg;
            v_mode  = mode_reg;
        end
    end

    always_comb
    begin
        vs_phase = PH_VALUE;
        vs_send  = 1'b0;
        vs_esc   = v_esc;
        vs_instr = v_instr;
        vs_depth = v_depth;
        if (v_em >= cap)
        begin
            vs_phase = PH_OK;
        end
        else if (v_esc)
        begin
            vs_esc  = 1'b0;
            vs_send = 1'b1;
        end
        else if (is_bslash)
        begin
            vs_esc  = 1'b1;
            vs_send = 1'b1;
        end
        else if (v_mode == MODE_QUOTED)
        begin
            if (is_quote)
            begin
                vs_phase = PH_OK;
            end
            else
            begin
                vs_send = 1'b1;
            end
        end
        else if (v_mode == MODE_BARE)
        begin
            if (is_quote || is_close || h == CH_COMMA)
            begin
                vs_phase = PH_OK;
            end
            else
            begin
                vs_send = 1'b1;
            end
        end
        else
        begin
            vs_send = 1'b1;
            if (is_quote)
            begin
                vs_instr = !v_instr;
            end
            else if (is_open && !v_instr)
            begin
                if (v_depth >= DEPTH_W'(NEST_MAX))
                begin
                    vs_phase = PH_BAD;
                    vs_send  = 1'b0;
                end
                else
                begin
                    vs_depth = v_depth + DEPTH_W'(1);
                end
            end
            else if (is_close && !v_instr)
            begin
                vs_depth = (v_depth != '0) ? v_depth - DEPTH_W'(1) : '0;
                if (vs_depth == '0)
                begin
                    vs_phase = PH_OK;
                end
            end
        end
    end

    always_comb
    begin
        if (phase_reg == PH_OK)
        begin
            status_code = jkv_pkg::STATUS_FOUND;
        end
        else if (phase_reg inside {PH_BAD, PH_POSTCOLON, PH_VALUE})
        begin
            status_code = jkv_pkg::STATUS_MALFORMED;
        end
        else
        begin
            status_code = jkv_pkg::STATUS_NOT_FOUND;
        end
    end

    always_comb
    begin
        fill_next      = fill_reg;
        phase_next     = phase_reg;
        skip_next      = skip_reg;
        instr_next     = instr_reg;
        esc_next       = esc_reg;
        depth_next     = depth_reg;
        mode_next      = mode_reg;
        emitted_next   = emitted_reg;
        last_pend_next = last_pend_reg;
        send_now       = 1'b0;
        for (int i = 0; i < KEY_MAX; i++)
        begin
            win_next[i] = wv[i];
        end

        if (step)
        begin
            fill_next      = fv;
            last_pend_next = lp;
        end

        if (handle)
        begin
            for (int i = 0; i < KEY_MAX - 1; i++)
            begin
                win_next[i] = wv[i + 1];
            end
            win_next[KEY_MAX - 1] = 8'd0;
            fill_next = fv - FILL_W'(1);

            case (phase_reg)
                PH_SEARCH:
                begin
                    if (esc_reg)
                    begin
                        esc_next = 1'b0;
                    end
                    else if (match)
                    begin
                        if (depth_reg <= DEPTH_W'(1))
                        begin
                            skip_next  = klen - FILL_W'(1);
                            phase_next = (klen != FILL_W'(1)) ? PH_SKIPKEY : PH_AFTERKEY;
                        end
                    end
                    else if (is_quote)
                    begin
                        instr_next = !instr_reg;
                    end
                    else if (is_bslash)
                    begin
                        if (instr_reg)
                        begin
                            esc_next = 1'b1;
                        end
                    end
                    else if (is_open && !instr_reg)
                    begin
                        if (depth_reg >= DEPTH_W'(NEST_MAX))
                        begin
                            phase_next = PH_BAD;
                        end
                        else
                        begin
                            depth_next = depth_reg + DEPTH_W'(1);
                        end
                    end
                    else if (is_close && !instr_reg)
                    begin
                        if (depth_reg == '0)
                        begin
                            phase_next = PH_BAD;
                        end
                        else
                        begin
                            depth_next = depth_reg - DEPTH_W'(1);
                        end
                    end
                end
                PH_SKIPKEY:
                begin
                    skip_next = (skip_reg != '0) ? skip_reg - FILL_W'(1) : '0;
                    if (skip_next == '0)
                    begin
                        phase_next = PH_AFTERKEY;
                    end
                end
                PH_AFTERKEY:
                begin
                    phase_next = is_quote ? PH_PRECOLON : PH_SEARCH;
                end
                PH_PRECOLON:
                begin
                    if (!is_blank)
                    begin
                        phase_next = (h == CH_COLON) ? PH_POSTCOLON : PH_SEARCH;
                    end
                end
                PH_POSTCOLON, PH_VALUE:
                begin
                    if (phase_reg == PH_POSTCOLON && is_blank)
                    begin
                        phase_next = PH_POSTCOLON;
                    end
                    else if (phase_reg == PH_POSTCOLON && is_quote)
                    begin
                        mode_next    = MODE_QUOTED;
                        emitted_next = 12'd0;
                        depth_next   = '0;
                        instr_next   = 1'b1;
                        esc_next     = 1'b0;
                        phase_next   = PH_VALUE;
                    end
                    else
                    begin
                        mode_next    = v_mode;
                        phase_next   = vs_phase;
                        esc_next     = vs_esc;
                        instr_next   = vs_instr;
                        depth_next   = vs_depth;
                        send_now     = vs_send;
                        emitted_next = vs_send ? v_em + 12'd1 : v_em;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        if (status_out)
        begin
            fill_next      = '0;
            phase_next     = PH_SEARCH;
            skip_next      = '0;
            instr_next     = 1'b0;
            esc_next       = 1'b0;
            depth_next     = '0;
            mode_next      = MODE_NONE;
            emitted_next   = 12'd0;
            last_pend_next = 1'b0;
        end
    end

    always_comb
    begin
        push              = (handle && send_now) || status_out;
        res.value_byte    = status_out ? 8'd0 : h;
        res.value_valid   = !status_out;
        res.result_status = status_out ? status_code : jkv_pkg::STATUS_FOUND;
        res.result_last   = status_out;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            phase_reg     <= PH_SEARCH;
            skip_reg      <= '0;
            instr_reg     <= 1'b0;
            esc_reg       <= 1'b0;
            depth_reg     <= '0;
            mode_reg      <= MODE_NONE;
            emitted_reg   <= 12'd0;
            last_pend_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            skip_reg      <= skip_next;
            instr_reg     <= instr_next;
            esc_reg       <= esc_next;
            depth_reg     <= depth_next;
            mode_reg      <= mode_next;
            emitted_reg   <= emitted_next;
            last_pend_reg <= last_pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < KEY_MAX; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    `JKV_ASSERT_IMPLIES(a_push_has_space, push, space, "result pushed into full buffer")
    `JKV_ASSERT_NEXT(a_status_clears, push && res.result_last,
        fill_reg == '0 && !last_pend_reg && phase_reg == PH_SEARCH,
        "document state not cleared after status")
    `JKV_ASSERT_IMPLIES(a_value_phase, push && res.value_valid,
        phase_reg == PH_VALUE || phase_reg == PH_POSTCOLON,
        "value byte sent outside value copy")
    `JKV_ASSERT_IMPLIES(a_last_from_take, $rose(last_pend_reg), $past(in_take && in_last),
        "end of document flagged without a final request")

endmodule

`default_nettype wire

FILE: sv/json_key_value_extractor.sv
// JSON key/value extractor: takes one document byte per cycle on the s_ stream while the
// core's key window is not full or draining and the output buffer has space, and returns
// the value bytes of the configured key on the m_ stream, followed by one status result
// (tlast high) per document. A byte passes an input register, the scan core and a
// two-entry output buffer, which registers the results. The core retires one window byte
// per cycle while the output buffer has space; after a document's final byte it retires
// the bytes still held in the key-length window (at most key_length - 1) and then sends
// the status; no request is taken during that drain. Write configuration only between documents.
// Depends on jkv_pkg, jkv_scan_core and jkv_out_fifo.
`default_nettype none

module json_key_value_extractor
#(
    parameter int KEY_MAX  = 16,
    parameter int NEST_MAX = 255
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [7:0] doc_byte
    input  wire logic        s_tlast,   // doc_last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [7:0] value_byte, [9:8] result_status, zero pad
    output logic             m_tuser,   // value_valid
    output logic             m_tlast,   // result_last
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [63:0] cfg_data
);

    logic [63:0]      key_low_word_reg;
    logic [63:0]      key_high_word_reg;
    logic [4:0]       key_length_reg;
    logic [12:0]      value_limit_reg;
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;
    logic             in_last_reg;
    logic             in_take;
    logic             space;
    logic             push;
    jkv_pkg::result_t res;
    jkv_pkg::result_t out_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_low_word_reg  <= 64'd0;
            key_high_word_reg <= 64'd0;
            key_length_reg    <= 5'd1;
            value_limit_reg   <= 13'd256;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                jkv_pkg::CFG_KEY_LOW:    key_low_word_reg  <= cfg_data;
                jkv_pkg::CFG_KEY_HIGH:   key_high_word_reg <= cfg_data;
                jkv_pkg::CFG_KEY_LENGTH: key_length_reg    <= cfg_data[4:0];
                jkv_pkg::CFG_VALUE_LIM:  value_limit_reg   <= cfg_data[12:0];
                default:                 key_length_reg    <= key_length_reg;
            endcase
        end
    end

    assign s_tready = !in_valid_reg || in_take;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_last_reg <= s_tlast;
        end
    end

    jkv_scan_core
    #(
        .KEY_MAX  (KEY_MAX),
        .NEST_MAX (NEST_MAX)
    )
    u_core
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .key_low_word  (key_low_word_reg),
        .key_high_word (key_high_word_reg),
        .key_length    (key_length_reg),
        .value_limit   (value_limit_reg),
        .in_valid      (in_valid_reg),
        .in_byte       (in_byte_reg),
        .in_last       (in_last_reg),
        .in_take       (in_take),
        .space         (space),
        .push          (push),
        .res           (res)
    );

    jkv_out_fifo u_out
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (res),
        .space     (space),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (out_data)
    );

    assign m_tdata = {6'd0, out_data.result_status, out_data.value_byte};
    assign m_tuser = out_data.value_valid;
    assign m_tlast = out_data.result_last;

endmodule

`default_nettype wire

FILE: tb/sv/tb_json_key_value_extractor.sv
`timescale 1ns / 100ps
// Self-checking bench for json_key_value_extractor: streams short JSON documents, some
// broken, under several key and value-limit settings and checks every value byte and
// status against a cycle-free model of the scanner. Depends on jkv_pkg and the RTL.

module tb_json_key_value_extractor;

    localparam int KEY_MAX  = 16;
    localparam int NEST_MAX = 255;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;

    typedef enum logic [2:0] {
        SCAN_SEARCH, SCAN_SKIPKEY, SCAN_AFTERKEY, SCAN_PRECOLON,
        SCAN_POSTCOLON, SCAN_VALUE, SCAN_OK, SCAN_BAD
    } scan_phase_t;

    typedef enum logic [1:0] {COPY_NONE, COPY_NEST, COPY_QUOTED, COPY_BARE} copy_mode_t;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = 8'h00;   // [7:0] doc_byte
    logic        s_tlast = 1'b0;    // doc_last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;           // [7:0] value_byte, [9:8] result_status, zero pad
    logic        m_tuser;           // value_valid
    logic        m_tlast;           // result_last
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [63:0] cfg_data;

    json_key_value_extractor uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // register copies
    logic [63:0] key_lo_r = 64'd0;
    logic [63:0] key_hi_r = 64'd0;
    logic [4:0]  key_len_r = 5'd1;
    logic [12:0] val_lim_r = 13'd256;

    // scanner copy
    logic [7:0]  win [KEY_MAX];
    int          win_fill = 0;
    scan_phase_t scan_at = SCAN_SEARCH;
    copy_mode_t  copy_as = COPY_NONE;
    int          skip_left = 0;
    bit          in_str = 1'b0;
    bit          esc_armed = 1'b0;
    int          depth = 0;
    int          sent_count = 0;

    jkv_pkg::result_t value_out_due[$];
    jkv_pkg::result_t due_head;
    logic [8:0]  doc_queue[$];      // {last, byte}
    logic [8:0]  sent_item;
    logic [7:0]  doc_text[$];
    logic [7:0]  cut_byte;
    logic [7:0]  cur_key [KEY_MAX];
    int          cur_klen = 1;
    int          phase_bytes = 0;
    int          mismatch_count = 0;

    bit          req_taken = 1'b0;
    int          burst_left = 6;
    int          gap_left = 0;
    logic [31:0] stall_pattern = 32'hFFFF_FFFF;
    logic [4:0]  stall_pos = 5'd0;

    task automatic report_mismatch(input string msg);
        $display("%0t ns: mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    function automatic bit is_open(input logic [7:0] h);
        return (h == CH_LBRACE) || (h == CH_LBRACK);
    endfunction

    function automatic bit is_close(input logic [7:0] h);
        return (h == CH_RBRACE) || (h == CH_RBRACK);
    endfunction

    function automatic bit is_blank(input logic [7:0] h);
        return (h == CH_SPACE) || (h == CH_TAB);
    endfunction

    function automatic int active_key_len();
        if (key_len_r == 5'd0)
            return 1;
        if (key_len_r > KEY_MAX)
            return KEY_MAX;
        return int'(key_len_r);
    endfunction

    function automatic logic [7:0] key_char(input int i);
        if (i < 8)
            return key_lo_r[8*i +: 8];
        return key_hi_r[8*(i-8) +: 8];
    endfunction

    function automatic void add_result(input logic [7:0] c, input logic v,
                                       input logic [1:0] st, input logic l);
        jkv_pkg::result_t r;
        r.value_byte    = c;
        r.value_valid   = v;
        r.result_status = st;
        r.result_last   = l;
        value_out_due.push_back(r);
    endfunction

    function automatic void clear_doc();
        int i;
        for (i = 0; i < KEY_MAX; i++)
            win[i] = 8'h00;
        win_fill   = 0;
        scan_at    = SCAN_SEARCH;
        skip_left  = 0;
        in_str     = 1'b0;
        esc_armed  = 1'b0;
        depth      = 0;
        copy_as    = COPY_NONE;
        sent_count = 0;
    endfunction

    function automatic void drop_head();
        int i;
        if (win_fill == 0)
            return;
        for (i = 0; i < KEY_MAX - 1; i++)
            win[i] = win[i+1];
        win[KEY_MAX-1] = 8'h00;
        win_fill--;
    endfunction

    function automatic void send_char(input logic [7:0] c);
        add_result(c, 1'b1, jkv_pkg::STATUS_FOUND, 1'b0);
        sent_count = (sent_count + 1) & 12'hFFF;
    endfunction

    function automatic void start_copy(input copy_mode_t m);
        copy_as    = m;
        sent_count = 0;
        depth      = 0;
        in_str     = (m != COPY_NEST);
        esc_armed  = 1'b0;
        scan_at    = SCAN_VALUE;
    endfunction

    function automatic void copy_step(input logic [7:0] h);
        int lim;
        int cap;
        lim = int'(val_lim_r);
        if (lim > 4096)
            lim = 4096;
        cap = (lim != 0) ? lim - 1 : 0;
        if (sent_count >= cap)
        begin
            scan_at = SCAN_OK;
            return;
        end
        if (esc_armed)
        begin
            esc_armed = 1'b0;
            send_char(h);
            return;
        end
        if (h == CH_BSLASH)
        begin
            esc_armed = 1'b1;
            send_char(h);
            return;
        end
        if (copy_as == COPY_QUOTED)
        begin
            if (h == CH_QUOTE)
                scan_at = SCAN_OK;
            else
                send_char(h);
            return;
        end
        if (copy_as == COPY_BARE)
        begin
            if (h == CH_QUOTE || h == CH_COMMA || is_close(h))
                scan_at = SCAN_OK;
            else
                send_char(h);
            return;
        end
        if (h == CH_QUOTE)
            in_str = !in_str;
        else if (is_open(h) && !in_str)
        begin
            if (depth >= NEST_MAX)
            begin
                scan_at = SCAN_BAD;
                return;
            end
            depth++;
        end
        else if (is_close(h) && !in_str)
        begin
            if (depth != 0)
                depth--;
            if (depth == 0)
            begin
                send_char(h);
                scan_at = SCAN_OK;
                return;
            end
        end
        send_char(h);
    endfunction

    function automatic void retire_head(input int klen);
        logic [7:0] h;
        bit hit;
        int i;
        h = win[0];
        case (scan_at)
            SCAN_SEARCH:
            begin
                if (esc_armed)
                begin
                    esc_armed = 1'b0;
                    drop_head();
                    return;
                end
                hit = (win_fill >= klen);
                for (i = 0; i < klen; i++)
                    if (win[i] != key_char(i))
                        hit = 1'b0;
                drop_head();
                if (hit)
                begin
                    if (depth > 1)
                        return;
                    skip_left = klen - 1;
                    if (skip_left != 0)
                        scan_at = SCAN_SKIPKEY;
                    else
                        scan_at = SCAN_AFTERKEY;
                    return;
                end
                if (h == CH_QUOTE)
                    in_str = !in_str;
                else if (h == CH_BSLASH)
                begin
                    if (in_str)
                        esc_armed = 1'b1;
                end
                else if (is_open(h) && !in_str)
                begin
                    if (depth >= NEST_MAX)
                        scan_at = SCAN_BAD;
                    else
                        depth++;
                end
                else if (is_close(h) && !in_str)
                begin
                    if (depth == 0)
                        scan_at = SCAN_BAD;
                    else
                        depth--;
                end
            end
            SCAN_SKIPKEY:
            begin
                drop_head();
                if (skip_left != 0)
                    skip_left--;
                if (skip_left == 0)
                    scan_at = SCAN_AFTERKEY;
            end
            SCAN_AFTERKEY:
            begin
                drop_head();
                if (h == CH_QUOTE)
                    scan_at = SCAN_PRECOLON;
                else
                    scan_at = SCAN_SEARCH;
            end
            SCAN_PRECOLON:
            begin
                drop_head();
                if (is_blank(h))
                    return;
                if (h == CH_COLON)
                    scan_at = SCAN_POSTCOLON;
                else
                    scan_at = SCAN_SEARCH;
            end
            SCAN_POSTCOLON:
            begin
                drop_head();
                if (is_blank(h))
                    return;
                if (h == CH_QUOTE)
                begin
                    start_copy(COPY_QUOTED);
                    return;
                end
                if (is_open(h))
                    start_copy(COPY_NEST);
                else
                    start_copy(COPY_BARE);
                copy_step(h);
            end
            SCAN_VALUE:
            begin
                drop_head();
                copy_step(h);
            end
            default:
                drop_head();
        endcase
    endfunction

    function automatic void scan_byte(input logic [7:0] b, input logic last);
        int klen;
        logic [1:0] st;
        klen = active_key_len();
        if (win_fill < KEY_MAX)
        begin
            win[win_fill] = b;
            win_fill++;
        end
        while (win_fill > 0 && (win_fill >= klen || last))
            retire_head(klen);
        if (last)
        begin
            if (scan_at == SCAN_OK)
                st = jkv_pkg::STATUS_FOUND;
            else if (scan_at == SCAN_BAD || scan_at == SCAN_POSTCOLON || scan_at == SCAN_VALUE)
                st = jkv_pkg::STATUS_MALFORMED;
            else
                st = jkv_pkg::STATUS_NOT_FOUND;
            add_result(8'h00, 1'b0, st, 1'b1);
            clear_doc();
        end
    endfunction

    // sender: bursts of requests separated by random gaps
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (req_taken)
            begin
                sent_item = doc_queue.pop_front();
                req_taken = 1'b0;
                burst_left--;
                if (burst_left <= 0)
                begin
                    burst_left = $urandom_range(1, 20);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                end
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else if (doc_queue.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= doc_queue[0][7:0];
                    s_tlast  <= doc_queue[0][8];
                end
                else
                    s_tvalid <= 1'b0;
            end
            else if (!s_tvalid)
            begin
                if (gap_left > 0)
                    gap_left--;
                else if (doc_queue.size() > 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= doc_queue[0][7:0];
                    s_tlast  <= doc_queue[0][8];
                end
            end
        end
    end

    // receiver: stall pattern redrawn each time the 5-bit stall position wraps
    always @(negedge clk)
    begin
        if (stall_pos == 5'd0)
        begin
            case ($urandom_range(0, 3))
                0: stall_pattern = 32'hFFFF_FFFF;
                1: stall_pattern = $urandom & $urandom;
                default: stall_pattern = $urandom;
            endcase
            stall_pattern[0] = 1'b1;
        end
        m_tready <= stall_pattern[stall_pos];
        stall_pos = stall_pos + 5'd1;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
            begin
                scan_byte(s_tdata, s_tlast);
                req_taken = 1'b1;
            end
            if (m_tvalid && m_tready)
            begin
                if (value_out_due.size() == 0)
                    report_mismatch($sformatf("unexpected result tdata=%h tuser=%b tlast=%b",
                                              m_tdata, m_tuser, m_tlast));
                else
                begin
                    due_head = value_out_due.pop_front();
                    if (m_tdata[7:0] !== due_head.value_byte)
                        report_mismatch($sformatf("value_byte got %h want %h",
                                                  m_tdata[7:0], due_head.value_byte));
                    if (m_tuser !== due_head.value_valid)
                        report_mismatch($sformatf("value_valid got %b want %b",
                                                  m_tuser, due_head.value_valid));
                    if (m_tdata[9:8] !== due_head.result_status)
                        report_mismatch($sformatf("result_status got %0d want %0d",
                                                  m_tdata[9:8], due_head.result_status));
                    if (m_tlast !== due_head.result_last)
                        report_mismatch($sformatf("result_last got %b want %b",
                                                  m_tlast, due_head.result_last));
                end
            end
        end
    end

    task automatic write_cfg(input logic [1:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            jkv_pkg::CFG_KEY_LOW:    key_lo_r  = val;
            jkv_pkg::CFG_KEY_HIGH:   key_hi_r  = val;
            jkv_pkg::CFG_KEY_LENGTH: key_len_r = val[4:0];
            jkv_pkg::CFG_VALUE_LIM:  val_lim_r = val[12:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic wait_idle();
        @(negedge clk);
        while (doc_queue.size() != 0 || s_tvalid || value_out_due.size() != 0)
            @(negedge clk);
        repeat (KEY_MAX + 4) @(negedge clk);
    endtask

    task automatic set_key_config(input int klen_reg, input int lim_reg);
        logic [63:0] lo;
        logic [63:0] hi;
        logic [63:0] word;
        logic [7:0]  c;
        int i;
        cur_klen = (klen_reg == 0) ? 1 : (klen_reg > KEY_MAX) ? KEY_MAX : klen_reg;
        lo = {$urandom, $urandom};
        hi = {$urandom, $urandom};
        for (i = 0; i < cur_klen; i++)
        begin
            if ($urandom_range(0, 9) < 7)
                c = 8'($urandom_range(8'h61, 8'h7A));
            else
                c = 8'($urandom_range(8'h80, 8'hFF));
            cur_key[i] = c;
            if (i < 8)
                lo[8*i +: 8] = c;
            else
                hi[8*(i-8) +: 8] = c;
        end
        write_cfg(jkv_pkg::CFG_KEY_LOW, lo);
        write_cfg(jkv_pkg::CFG_KEY_HIGH, hi);
        word = {$urandom, $urandom};
        word[4:0] = 5'(klen_reg);
        write_cfg(jkv_pkg::CFG_KEY_LENGTH, word);
        word = {$urandom, $urandom};
        word[12:0] = 13'(lim_reg);
        write_cfg(jkv_pkg::CFG_VALUE_LIM, word);
    endtask

    task automatic add_byte(input logic [7:0] c);
        doc_text.push_back(c);
    endtask

    task automatic flush_doc();
        int i;
        if (doc_text.size() == 0)
            doc_text.push_back(8'h78);
        for (i = 0; i < doc_text.size(); i++)
            doc_queue.push_back({(i == doc_text.size() - 1) ? 1'b1 : 1'b0, doc_text[i]});
        phase_bytes += doc_text.size();
        doc_text.delete();
    endtask

    task automatic queue_text(input string s);
        int i;
        for (i = 0; i < s.len(); i++)
            add_byte(s[i]);
        flush_doc();
    endtask

    task automatic add_key(input bit mutate);
        int i;
        int pos;
        logic [7:0] c;
        pos = $urandom_range(0, cur_klen - 1);
        for (i = 0; i < cur_klen; i++)
        begin
            c = cur_key[i];
            if (mutate && i == pos)
                c = (c == 8'hFF) ? 8'h01 : c + 8'd1;
            add_byte(c);
        end
    endtask

    task automatic add_blanks();
        int n;
        n = $urandom_range(0, 2);
        repeat (n) add_byte($urandom_range(0, 1) ? CH_SPACE : CH_TAB);
    endtask

    task automatic add_bare();
        string digits;
        int n;
        digits = "0123456789-.etrufaln";
        n = $urandom_range(1, 5);
        repeat (n) add_byte(digits[$urandom_range(0, digits.len() - 1)]);
    endtask

    function automatic logic [7:0] text_char();
        logic [7:0] c;
        case ($urandom_range(0, 9))
            6, 7, 8: c = 8'($urandom_range(8'h80, 8'hFF));
            9:       c = 8'($urandom_range(8'h01, 8'h1F));
            default: c = 8'($urandom_range(8'h20, 8'h7E));
        endcase
        if (c == CH_QUOTE || c == CH_BSLASH)
            c = 8'h7A;
        return c;
    endfunction

    task automatic add_quoted();
        int n;
        add_byte(CH_QUOTE);
        n = $urandom_range(0, 5);
        repeat (n)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                add_byte(CH_BSLASH);
                add_byte($urandom_range(0, 1) ? CH_QUOTE : text_char());
            end
            else
                add_byte(text_char());
        end
        add_byte(CH_QUOTE);
    endtask

    function automatic logic [7:0] special_char();
        case ($urandom_range(0, 7))
            0: return CH_LBRACE;
            1: return CH_RBRACE;
            2: return CH_LBRACK;
            3: return CH_RBRACK;
            4: return CH_QUOTE;
            5: return CH_BSLASH;
            6: return CH_COLON;
            default: return CH_COMMA;
        endcase
    endfunction

    task automatic add_member(input int level);
        int kind;
        int n;
        add_byte(CH_QUOTE);
        kind = $urandom_range(0, 9);
        if (kind < 4)
            add_key(1'b0);
        else if (kind < 6)
            add_key(1'b1);
        else
        begin
            n = $urandom_range(1, 4);
            repeat (n) add_byte(8'($urandom_range(8'h61, 8'h7A)));
        end
        add_byte(CH_QUOTE);
        add_blanks();
        add_byte(CH_COLON);
        add_blanks();
        kind = $urandom_range(0, 9);
        if (kind < 4)
            add_quoted();
        else if (kind < 7 || level > 0)
            add_bare();
        else if (kind == 7)
        begin
            add_byte(CH_LBRACK);
            add_bare();
            add_byte(CH_COMMA);
            add_quoted();
            add_byte(CH_RBRACK);
        end
        else
        begin
            add_byte(CH_LBRACE);
            add_member(level + 1);
            add_byte(CH_RBRACE);
        end
    endtask

    task automatic build_doc();
        int n;
        int i;
        int cut;
        if ($urandom_range(0, 3) != 0)
        begin
            if ($urandom_range(0, 3) == 0)
                add_blanks();
            add_byte(CH_LBRACE);
            n = $urandom_range(1, 3);
            for (i = 0; i < n; i++)
            begin
                if (i != 0)
                begin
                    add_byte(CH_COMMA);
                    add_blanks();
                end
                add_member(0);
            end
            add_byte(CH_RBRACE);
            // cut some documents short
            if ($urandom_range(0, 6) == 0)
            begin
                cut = $urandom_range(1, doc_text.size());
                while (doc_text.size() > cut)
                    cut_byte = doc_text.pop_back();
            end
        end
        else
        begin
            n = $urandom_range(1, 10);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    4: add_byte(special_char());
                    5: add_byte(cur_key[$urandom_range(0, cur_klen - 1)]);
                    default: add_byte(8'($urandom_range(1, 255)));
                endcase
            end
        end
        flush_doc();
    endtask

    initial
    begin
        int p;
        int klen;
        int lim;
        logic [63:0] word;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = jkv_pkg::CFG_KEY_LOW;
        cfg_data  = 64'd0;
        clear_doc();
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // close at depth zero under the reset key
        queue_text("]");
        wait_idle();

        word = {$urandom, $urandom};
        word[7:0] = 8'h6B;
        cur_key[0] = 8'h6B;
        cur_klen = 1;
        write_cfg(jkv_pkg::CFG_KEY_LOW, word);
        write_cfg(jkv_pkg::CFG_KEY_HIGH, {$urandom, $urandom});
        write_cfg(jkv_pkg::CFG_KEY_LENGTH, 64'd1);
        queue_text("k\"\t:\t7}");
        queue_text("k\":\"\\\"");
        queue_text("k\":[{}]");
        queue_text("xk\"");
        queue_text("k\":");

        for (p = 0; p < 8; p++)
        begin
            case (p)
                0: begin klen = 1;  lim = 256;  end
                1: begin klen = 2;  lim = 1;    end
                2: begin klen = 16; lim = 4096; end
                3: begin klen = 3;  lim = 3;    end
                4: begin klen = 0;  lim = 0;    end
                5: begin klen = 5;  lim = 8191; end
                6: begin klen = 20; lim = 6;    end
                default: begin klen = 8; lim = 40; end
            endcase
            wait_idle();
            set_key_config(klen, lim);
            phase_bytes = 0;
            while (phase_bytes < 12)
                build_doc();
        end

        // nesting past the depth limit while copying
        wait_idle();
        set_key_config(1, 4096);
        add_key(1'b0);
        add_byte(CH_QUOTE);
        add_byte(CH_COLON);
        repeat (NEST_MAX + 1) add_byte(CH_LBRACK);
        flush_doc();

        wait_idle();
        if (mismatch_count == 0)
            $display("tb_json_key_value_extractor: PASS");
        else
            $display("tb_json_key_value_extractor: FAIL");
        $finish;
    end

    initial
    begin
        #5000000;
        $display("tb_json_key_value_extractor: FAIL");
        $finish;
    end

endmodule
